// File: sv/ewl_pkg.sv
// shared types and constants for the eeprom wear-level slot manager
// no dependencies; imported by ewl_ring_scan and the core top level
`timescale 1ns / 1ps

package ewl_pkg;

    localparam int EWL_SLOTS       = 60;
    localparam int EWL_SLOT_BYTES  = 16;
    localparam int EWL_STORE_BYTES = 1024;

    localparam int EWL_KIND_W  = 2;
    localparam int EWL_INDEX_W = 6;
    localparam int EWL_BYTE_W  = 8;
    localparam int EWL_ADDR_W  = 10;
    localparam int EWL_DELAY_W = 16;
    localparam int EWL_IDX_W   = 8;

    localparam logic [EWL_DELAY_W-1:0] EWL_DELAY_RESET = 16'd3000;
    localparam logic [EWL_DELAY_W-1:0] EWL_TICK_MAX    = 16'hFFFF;

    localparam logic [EWL_KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [EWL_KIND_W-1:0] KIND_CHANGE = 2'd1;
    localparam logic [EWL_KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [EWL_KIND_W-1:0] KIND_LOCATE = 2'd3;

    localparam logic RES_COMMIT = 1'b0;
    localparam logic RES_LOCATE = 1'b1;

    typedef struct packed {
        logic start;
        logic ack;
        logic commit;
    } ewl_ctl_t;

    typedef struct packed {
        logic                 done;
        logic [EWL_IDX_W-1:0]  slot;
        logic [EWL_BYTE_W-1:0] sval;
    } ewl_stat_t;

endpackage

// File: sv/eeprom_wear_level_slot_manager_core.sv
// top level of the eeprom wear-level slot manager: request handling, save timer,
// result register; depends on ewl_pkg and ewl_ring_scan
//
// usage:
//   s_ channel: one request per handshake (kind, entry_index, entry_value).
//     load, change and tick requests are taken one per cycle while no scan runs, as
//     s_ready is then high, so they may follow back to back. a locate request, or
//     a tick that pushes the timer past save_delay, starts a scan of the status
//     ring memory, one entry per cycle.
//   m_ channel: a commit or locate result comes from the ring scan (states PRE,
//     FIRST, SCAN, DONE) and is then registered; the scan length is set by the
//     first break in the status sequence. s_ready stays low until the result is
//     in the output register, so one scan runs at a time.
//   cfg channel: writes save_delay, always ready; write only while idle.
//   reset: timer and pending flag clear, save_delay returns to 3000; the ring
//     contents are undefined until loaded, no clearing pass is run.
//   stall: a held result keeps the finished scan waiting; simple requests are
//     still taken while m_valid waits for m_ready.
`timescale 1ns / 1ps

module eeprom_wear_level_slot_manager_core
    import ewl_pkg::*;
#(
    parameter int SLOTS       = EWL_SLOTS,
    parameter int SLOT_BYTES  = EWL_SLOT_BYTES,
    parameter int STORE_BYTES = EWL_STORE_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [EWL_KIND_W-1:0]  s_kind,
    input  logic [EWL_INDEX_W-1:0] s_entry_index,
    input  logic [EWL_BYTE_W-1:0]  s_entry_value,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [EWL_DELAY_W-1:0] cfg_data,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_result_kind,
    output logic [EWL_INDEX_W-1:0] m_write_slot,
    output logic [EWL_ADDR_W-1:0]  m_write_address,
    output logic [EWL_ADDR_W-1:0]  m_status_address,
    output logic [EWL_BYTE_W-1:0]  m_status_value,
    output logic [EWL_INDEX_W-1:0] m_read_slot,
    output logic [EWL_ADDR_W-1:0]  m_read_address
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                   state_reg, state_next;
    logic                   pending_reg, pending_next;
    logic [EWL_DELAY_W-1:0] ticks_reg, ticks_next;
    logic [EWL_DELAY_W-1:0] delay_reg;
    logic                   commit_reg, commit_next;
    logic                   m_valid_reg, m_valid_next;

    logic                   accept;
    logic                   emit;
    logic [EWL_DELAY_W-1:0] ticks_inc;
    logic                   load_en;
    logic [SLOT_W-1:0]      slot_w;
    logic [SLOT_W-1:0]      rslot_w;
    ewl_ctl_t               ctl;
    ewl_stat_t              stat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign accept    = s_valid && s_ready;
    assign emit      = (state_reg == ST_BUSY) && stat.done && (!m_valid_reg || m_ready);
    assign ticks_inc = (ticks_reg == EWL_TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign load_en   = accept && (s_kind == KIND_LOAD) && (int'(s_entry_index) < SLOTS);

    assign slot_w  = stat.slot[SLOT_W-1:0];
    assign rslot_w = commit_reg ? slot_w : ((slot_w == '0) ? LAST : slot_w - 1'b1);

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        ticks_next   = ticks_reg;
        commit_next  = commit_reg;
        ctl.start    = 1'b0;
        ctl.ack      = emit;
        ctl.commit   = commit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            unique case (s_kind)
                KIND_LOAD: begin
                end
                KIND_CHANGE: begin
                    pending_next = 1'b1;
                    ticks_next   = '0;
                end
                KIND_TICK: begin
                    if (pending_reg) begin
                        if (ticks_inc > delay_reg) begin
                            pending_next = 1'b0;
                            ticks_next   = '0;
                            commit_next  = 1'b1;
                            ctl.start    = 1'b1;
                            state_next   = ST_BUSY;
                        end else begin
                            ticks_next = ticks_inc;
                        end
                    end
                end
                KIND_LOCATE: begin
                    commit_next = 1'b0;
                    ctl.start   = 1'b1;
                    state_next  = ST_BUSY;
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            m_valid_next = 1'b1;
            state_next   = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            ticks_reg   <= '0;
            delay_reg   <= EWL_DELAY_RESET;
            m_valid_reg <= 1'b0;
            commit_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            ticks_reg   <= ticks_next;
            m_valid_reg <= m_valid_next;
            commit_reg  <= commit_next;
            if (cfg_valid && cfg_ready) begin
                delay_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_result_kind    <= commit_reg ? RES_COMMIT : RES_LOCATE;
            m_write_slot     <= EWL_INDEX_W'(slot_w);
            m_write_address  <= EWL_ADDR_W'(SLOT_BYTES * int'(slot_w));
            m_status_address <= EWL_ADDR_W'(STORE_BYTES - SLOTS + int'(slot_w));
            m_status_value   <= stat.sval;
            m_read_slot      <= EWL_INDEX_W'(rslot_w);
            m_read_address   <= EWL_ADDR_W'(SLOT_BYTES * int'(rslot_w));
        end
    end

    ewl_ring_scan #(
        .SLOTS (SLOTS)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .load_en  (load_en),
        .load_idx (SLOT_W'(s_entry_index)),
        .load_val (s_entry_value),
        .stat     (stat)
    );

    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        !pending_reg |-> (ticks_reg == '0))
        else $error("timer running with no save pending");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> (state_reg == ST_BUSY))
        else $error("scan finished while no request in flight");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> (int'(slot_w) < SLOTS))
        else $error("scan returned a slot beyond the ring");

    a_emit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid)
        else $error("result lost after scan");

endmodule

// File: sv/ewl_ring_scan.sv
// status ring memory with the sequential scan for the write slot
// depends on ewl_pkg
`timescale 1ns / 1ps

module ewl_ring_scan
    import ewl_pkg::*;
#(
    parameter int  SLOTS  = EWL_SLOTS,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ewl_ctl_t              ctl,
    input  logic                  load_en,
    input  logic [SLOT_W-1:0]     load_idx,
    input  logic [EWL_BYTE_W-1:0] load_val,
    output ewl_stat_t             stat
);

    localparam logic [2:0] SC_IDLE  = 3'd0;
    localparam logic [2:0] SC_PRE   = 3'd1;
    localparam logic [2:0] SC_FIRST = 3'd2;
    localparam logic [2:0] SC_SCAN  = 3'd3;
    localparam logic [2:0] SC_DONE  = 3'd4;

    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

    logic [EWL_BYTE_W-1:0] ring [SLOTS];
    logic [EWL_BYTE_W-1:0] rdata_reg;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [EWL_BYTE_W-1:0] prev_reg, prev_next;
    logic [EWL_BYTE_W-1:0] first_reg, first_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [EWL_BYTE_W-1:0] sval_reg, sval_next;

    logic [SLOT_W-1:0]     raddr;
    logic                  we;
    logic [SLOT_W-1:0]     waddr;
    logic [EWL_BYTE_W-1:0] wdata;
    logic [EWL_BYTE_W-1:0] expect_val;

    assign expect_val = prev_reg + 8'd1;

    assign we    = load_en || (ctl.ack && ctl.commit);
    assign waddr = load_en ? load_idx : slot_reg;
    assign wdata = load_en ? load_val : sval_reg;

    always_comb begin
        unique case (state_reg)
            SC_PRE:  raddr = LAST;
            SC_SCAN: raddr = (cnt_reg == LAST) ? '0 : cnt_reg + 1'b1;
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            ring[waddr] <= wdata;
        end
        rdata_reg <= ring[raddr];
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        slot_next  = slot_reg;
        sval_next  = sval_reg;
        unique case (state_reg)
            SC_IDLE: begin
                if (ctl.start) begin
                    state_next = SC_PRE;
                end
            end
            SC_PRE: begin
                state_next = SC_FIRST;
            end
            SC_FIRST: begin
                prev_next  = rdata_reg;
                first_next = rdata_reg;
                cnt_next   = '0;
                state_next = SC_SCAN;
            end
            SC_SCAN: begin
                priority if (expect_val != rdata_reg) begin
                    slot_next  = cnt_reg;
                    sval_next  = expect_val;
                    state_next = SC_DONE;
                end else if (cnt_reg == LAST) begin
                    slot_next  = '0;
                    sval_next  = first_reg + 8'd1;
                    state_next = SC_DONE;
                end else begin
                    prev_next = rdata_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            SC_DONE: begin
                if (ctl.ack) begin
                    state_next = SC_IDLE;
                end
            end
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        prev_reg  <= prev_next;
        first_reg <= first_next;
        slot_reg  <= slot_next;
        sval_reg  <= sval_next;
    end

    assign stat.done = (state_reg == SC_DONE);
    assign stat.slot = EWL_IDX_W'(slot_reg);
    assign stat.sval = sval_reg;

endmodule

// File: bench/tb_top.sv
// self-checking bench for eeprom_wear_level_slot_manager_core: named tests drive requests,
// a local copy of the status ring and save timer predicts every commit and locate answer
// depends on ewl_pkg and the core top level
`timescale 1ns / 1ps

module tb_top;
    import ewl_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = EWL_SLOTS + 16;

    typedef struct {
        logic                   result_kind;
        logic [EWL_INDEX_W-1:0] write_slot;
        logic [EWL_ADDR_W-1:0]  write_address;
        logic [EWL_ADDR_W-1:0]  status_address;
        logic [EWL_BYTE_W-1:0]  status_value;
        logic [EWL_INDEX_W-1:0] read_slot;
        logic [EWL_ADDR_W-1:0]  read_address;
    } slot_report_t;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [EWL_KIND_W-1:0]  s_kind        = KIND_LOAD;
    logic [EWL_INDEX_W-1:0] s_entry_index = '0;
    logic [EWL_BYTE_W-1:0]  s_entry_value = '0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [EWL_DELAY_W-1:0] cfg_data      = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_result_kind;
    logic [EWL_INDEX_W-1:0] m_write_slot;
    logic [EWL_ADDR_W-1:0]  m_write_address;
    logic [EWL_ADDR_W-1:0]  m_status_address;
    logic [EWL_BYTE_W-1:0]  m_status_value;
    logic [EWL_INDEX_W-1:0] m_read_slot;
    logic [EWL_ADDR_W-1:0]  m_read_address;

    // local copy of the block state
    logic [EWL_BYTE_W-1:0]  ring_copy [EWL_SLOTS] = '{default: '0};
    logic                   save_armed = 1'b0;
    logic [EWL_DELAY_W-1:0] tick_count = '0;
    logic [EWL_DELAY_W-1:0] delay_copy = EWL_DELAY_RESET;

    slot_report_t awaited_results [$];
    slot_report_t head_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int request_count  = 0;
    int commit_count   = 0;
    int locate_count   = 0;
    int cycle_count    = 0;

    eeprom_wear_level_slot_manager_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_entry_index    (s_entry_index),
        .s_entry_value    (s_entry_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_write_slot     (m_write_slot),
        .m_write_address  (m_write_address),
        .m_status_address (m_status_address),
        .m_status_value   (m_status_value),
        .m_read_slot      (m_read_slot),
        .m_read_address   (m_read_address)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned prior_slot(input int unsigned slot);
        return (slot == 0) ? EWL_SLOTS - 1 : slot - 1;
    endfunction

    function automatic int unsigned first_break();
        logic [EWL_BYTE_W-1:0] follow;
        for (int i = 0; i < EWL_SLOTS; i++) begin
            follow = ring_copy[prior_slot(i)] + 1'b1;
            if (ring_copy[i] != follow) return i;
        end
        return 0;
    endfunction

    function automatic slot_report_t make_report(input logic kind, input int unsigned slot,
                                                 input int unsigned rslot);
        slot_report_t rep;
        rep.result_kind    = kind;
        rep.write_slot     = EWL_INDEX_W'(slot);
        rep.write_address  = EWL_ADDR_W'(slot * EWL_SLOT_BYTES);
        rep.status_address = EWL_ADDR_W'(EWL_STORE_BYTES - EWL_SLOTS + slot);
        rep.status_value   = ring_copy[prior_slot(slot)] + 1'b1;
        rep.read_slot      = EWL_INDEX_W'(rslot);
        rep.read_address   = EWL_ADDR_W'(rslot * EWL_SLOT_BYTES);
        return rep;
    endfunction

    // update the local state for one accepted request, queue any answer
    function automatic void apply_request(input logic [EWL_KIND_W-1:0] kind,
                                          input logic [EWL_INDEX_W-1:0] index,
                                          input logic [EWL_BYTE_W-1:0] value);
        int unsigned slot;
        slot_report_t rep;
        case (kind)
            KIND_LOAD: begin
                if (index < EWL_SLOTS) ring_copy[index] = value;
            end
            KIND_CHANGE: begin
                save_armed = 1'b1;
                tick_count = '0;
            end
            KIND_TICK: begin
                if (save_armed) begin
                    if (tick_count != EWL_TICK_MAX) tick_count = tick_count + 1'b1;
                    if (tick_count > delay_copy) begin
                        slot = first_break();
                        rep = make_report(RES_COMMIT, slot, slot);
                        ring_copy[slot] = rep.status_value;
                        save_armed = 1'b0;
                        tick_count = '0;
                        awaited_results.push_back(rep);
                        commit_count++;
                    end
                end
            end
            default: begin
                slot = first_break();
                awaited_results.push_back(make_report(RES_LOCATE, slot, prior_slot(slot)));
                locate_count++;
            end
        endcase
    endfunction

    task automatic send_request(input logic [EWL_KIND_W-1:0] kind,
                                input logic [EWL_INDEX_W-1:0] index,
                                input logic [EWL_BYTE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_entry_index <= index;
        s_entry_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(kind, index, value);
        if (!(kind == KIND_LOAD && index >= EWL_SLOTS)) request_count++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_delay(input logic [EWL_DELAY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        delay_copy = value;
        cfg_valid <= 1'b0;
    endtask

    // consecutive status bytes from base over slots 0..len-1, break at len
    task automatic load_run(input logic [EWL_BYTE_W-1:0] base, input int len);
        send_request(KIND_LOAD, EWL_INDEX_W'(EWL_SLOTS - 1), base - 1'b1);
        for (int i = 0; i < len; i++)
            send_request(KIND_LOAD, EWL_INDEX_W'(i), EWL_BYTE_W'(base + i));
        if (len < EWL_SLOTS - 1)
            send_request(KIND_LOAD, EWL_INDEX_W'(len), EWL_BYTE_W'(base + len + 1));
    endtask

    task automatic test_ring_load();
        load_run(8'hFC, EWL_SLOTS - 1);
        send_request(KIND_LOAD, 6'd60, 8'h00);
        send_request(KIND_LOAD, 6'd63, 8'hFF);
        send_request(KIND_LOCATE, '0, '0);
        send_request(KIND_LOAD, 6'd0, 8'h00);
        send_request(KIND_LOCATE, 6'd63, 8'hFF);
        send_request(KIND_TICK, '0, '0);
        drain_results();
    endtask

    task automatic test_default_delay();
        send_request(KIND_CHANGE, '0, '0);
        repeat (10) send_request(KIND_TICK, '0, '0);
        send_request(KIND_LOCATE, '0, '0);
        drain_results();
    endtask

    task automatic test_zero_delay();
        write_delay('0);
        send_request(KIND_CHANGE, '0, '0);
        send_request(KIND_TICK, '0, '0);
        send_request(KIND_TICK, '0, '0);
        send_request(KIND_CHANGE, '0, '0);
        send_request(KIND_CHANGE, '0, '0);
        send_request(KIND_TICK, '0, '0);
        send_request(KIND_LOCATE, '0, '0);
        drain_results();
    endtask

    task automatic test_change_restart();
        write_delay(16'd3);
        send_request(KIND_CHANGE, '0, '0);
        send_request(KIND_TICK, '0, '0);
        send_request(KIND_TICK, '0, '0);
        send_request(KIND_CHANGE, '0, '0);
        repeat (4) send_request(KIND_TICK, '0, '0);
        send_request(KIND_LOCATE, '0, '0);
        drain_results();
    endtask

    task automatic test_long_delay();
        write_delay(EWL_TICK_MAX);
        send_request(KIND_CHANGE, '0, '0);
        repeat (20) send_request(KIND_TICK, '0, '0);
        drain_results();
        write_delay(16'd4);
        send_request(KIND_TICK, '0, '0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [EWL_DELAY_W-1:0] delay, input int quota);
        int first;
        int pick;
        int len;
        drain_results();
        write_delay(delay);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first = request_count;
        while (request_count - first < quota) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                len = ($urandom_range(4) == 0) ? $urandom_range(EWL_SLOTS - 1, 13)
                                               : $urandom_range(12);
                load_run(EWL_BYTE_W'($urandom), len);
            end else if (pick < 16) begin
                send_request(KIND_LOAD, EWL_INDEX_W'($urandom), EWL_BYTE_W'($urandom));
            end else if (pick < 36) begin
                send_request(KIND_CHANGE, EWL_INDEX_W'($urandom), EWL_BYTE_W'($urandom));
            end else if (pick < 80) begin
                send_request(KIND_TICK, EWL_INDEX_W'($urandom), EWL_BYTE_W'($urandom));
            end else begin
                send_request(KIND_LOCATE, EWL_INDEX_W'($urandom), EWL_BYTE_W'($urandom));
            end
        end
        drain_results();
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with no request waiting for one");
                error_count++;
            end else begin
                head_result = awaited_results.pop_front();
                compare_field("result_kind", head_result.result_kind, m_result_kind);
                compare_field("write_slot", head_result.write_slot, m_write_slot);
                compare_field("write_address", head_result.write_address, m_write_address);
                compare_field("status_address", head_result.status_address, m_status_address);
                compare_field("status_value", head_result.status_value, m_status_value);
                compare_field("read_slot", head_result.read_slot, m_read_slot);
                compare_field("read_address", head_result.read_address, m_read_address);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ring_load();
        test_default_delay();
        test_zero_delay();
        test_change_restart();
        test_long_delay();
        test_random_traffic(0, 0, 16'd0, 80);
        test_random_traffic(78, 0, 16'd2, 80);
        test_random_traffic(0, 78, 16'd1, 80);
        test_random_traffic(33, 33, 16'($urandom_range(6, 3)), 80);
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            error_count++;
        end
        $display("covered %0d requests with %0d save commits and %0d locate answers,",
                 request_count, commit_count, locate_count);
        $display("short, default and maximum save delays, restarts and four handshake mixes");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
